@@ hw/rtl/pwc_pkg.sv @@
// shared types, constants and helpers of the packet whitelist classifier
package pwc_pkg;

    localparam int LANES = 16;
    localparam int LANE_W = $clog2(LANES);

    localparam int V4_ENTRIES = 1024;
    localparam int V6_ENTRIES = 1024;
    localparam int PORT_ENTRIES = 128;

    localparam int V4_ROWS = (V4_ENTRIES + LANES - 1) / LANES;
    localparam int V6_ROWS = (V6_ENTRIES + LANES - 1) / LANES;
    localparam int PORT_ROWS = (PORT_ENTRIES + LANES - 1) / LANES;
    localparam int MAX_ROWS_A = (V4_ROWS > V6_ROWS) ? V4_ROWS : V6_ROWS;
    localparam int MAX_ROWS = (MAX_ROWS_A > PORT_ROWS) ? MAX_ROWS_A : PORT_ROWS;
    localparam int ROW_W = $clog2(MAX_ROWS + 1);

    localparam int V4_AW = (V4_ROWS > 1) ? $clog2(V4_ROWS) : 1;
    localparam int V6_AW = (V6_ROWS > 1) ? $clog2(V6_ROWS) : 1;
    localparam int PORT_AW = (PORT_ROWS > 1) ? $clog2(PORT_ROWS) : 1;

    localparam logic [1:0] REQ_CLASSIFY = 2'd0;
    localparam logic [1:0] REQ_V4 = 2'd1;
    localparam logic [1:0] REQ_V6 = 2'd2;
    localparam logic [1:0] REQ_PORT = 2'd3;

    localparam logic [2:0] ETH_FAIL = 3'd0;
    localparam logic [2:0] ETH_ARP = 3'd1;
    localparam logic [2:0] ETH_IPV4 = 3'd2;
    localparam logic [2:0] ETH_IPV6 = 3'd3;

    localparam logic [7:0] IPN_ICMP = 8'd1;
    localparam logic [7:0] IPN_TCP = 8'd6;
    localparam logic [7:0] IPN_UDP = 8'd17;
    localparam logic [7:0] IPN_ICMPV6 = 8'd58;

    localparam logic [7:0] ALLOW_TCP = 8'(1 << 0);
    localparam logic [7:0] ALLOW_UDP = 8'(1 << 1);
    localparam logic [7:0] ALLOW_ICMP = 8'(1 << 2);
    localparam logic [7:0] ALLOW_ICMPV6 = 8'(1 << 3);

    localparam logic [1:0] VERDICT_PASS = 2'd0;
    localparam logic [1:0] VERDICT_DROP = 2'd1;
    localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

    localparam logic [1:0] MATCH_NONE = 2'd0;
    localparam logic [1:0] MATCH_SOURCE = 2'd1;
    localparam logic [1:0] MATCH_PORT = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    typedef enum logic [1:0] {TBL_V4, TBL_V6, TBL_PORT} tbl_t;
    typedef enum logic [1:0] {CMD_DONE, CMD_LOOKUP, CMD_UPDATE} cmd_kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        remove_entry;
        logic [7:0]  allow_mask;
        logic [2:0]  eth_kind;
        logic        l3_ok;
        logic [7:0]  ip_protocol;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic        l4_ok;
        logic [15:0] dest_port;
    } req_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] matched_table;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        cmd_kind_t    kind;
        tbl_t         tbl;
        logic [1:0]   verdict;
        logic         remove_entry;
        logic         port_chk;
        logic [7:0]   allow_mask;
        logic [7:0]   pm;
        logic [127:0] key;
        logic [15:0]  port;
    } cmd_t;

    typedef struct packed {
        logic [LANES-1:0]        used;
        logic [LANES-1:0][31:0]  key;
        logic [LANES-1:0][7:0]   allow;
    } v4_row_t;

    typedef struct packed {
        logic [LANES-1:0]        used;
        logic [LANES-1:0][127:0] key;
        logic [LANES-1:0][7:0]   allow;
    } v6_row_t;

    typedef struct packed {
        logic [LANES-1:0]        used;
        logic [LANES-1:0][15:0]  key;
        logic [LANES-1:0][7:0]   allow;
    } port_row_t;

    typedef struct packed {
        logic [LANES-1:0]        used;
        logic [LANES-1:0][127:0] key;
        logic [LANES-1:0][7:0]   allow;
    } gen_row_t;

    function automatic logic [7:0] proto_bit(input logic [7:0] p);
        logic [7:0] r;
        r = 8'd0;
        if (p == IPN_TCP) r = ALLOW_TCP;
        else if (p == IPN_UDP) r = ALLOW_UDP;
        else if (p == IPN_ICMP) r = ALLOW_ICMP;
        else if (p == IPN_ICMPV6) r = ALLOW_ICMPV6;
        return r;
    endfunction

endpackage

@@ hw/rtl/pwc_ram.sv @@
// simple dual port row memory with registered read
module pwc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/pwc_front.sv @@
// front end: request decode and two-entry command queue
module pwc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pwc_pkg::req_t item,
    input  logic          clearing,
    output logic          busy,
    input  logic          pop,
    output logic          cmd_valid,
    output pwc_pkg::cmd_t cmd
);
    import pwc_pkg::*;

    cmd_t       dec;
    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop_ok;

    always_comb
    begin
        dec = '0;
        dec.kind = CMD_DONE;
        dec.tbl = TBL_V4;
        dec.verdict = VERDICT_PASS;
        dec.remove_entry = item.remove_entry;
        dec.allow_mask = item.allow_mask;
        dec.pm = proto_bit(item.ip_protocol);
        dec.port = item.dest_port;
        dec.port_chk = ((item.ip_protocol == IPN_TCP) || (item.ip_protocol == IPN_UDP))
                       && item.l4_ok;
        case (item.req_type)
            REQ_V4:
            begin
                dec.kind = CMD_UPDATE;
                dec.tbl = TBL_V4;
                dec.key = {96'd0, item.src_addr_low[31:0]};
            end
            REQ_V6:
            begin
                dec.kind = CMD_UPDATE;
                dec.tbl = TBL_V6;
                dec.key = {item.src_addr_high, item.src_addr_low};
            end
            REQ_PORT:
            begin
                dec.kind = CMD_UPDATE;
                dec.tbl = TBL_PORT;
            end
            default:
            begin
                if (item.eth_kind == ETH_ARP)
                begin
                    dec.verdict = VERDICT_REDIRECT;
                end
                else if (item.eth_kind == ETH_IPV4 || item.eth_kind == ETH_IPV6)
                begin
                    if (!item.l3_ok)
                    begin
                        dec.verdict = (item.eth_kind == ETH_IPV6) ? VERDICT_DROP
                                                                  : VERDICT_PASS;
                    end
                    else if (item.eth_kind == ETH_IPV4)
                    begin
                        dec.kind = CMD_LOOKUP;
                        dec.tbl = TBL_V4;
                        dec.key = {96'd0, item.src_addr_low[31:0]};
                    end
                    else
                    begin
                        dec.kind = CMD_LOOKUP;
                        dec.tbl = TBL_V6;
                        dec.key = {item.src_addr_high, item.src_addr_low};
                    end
                end
            end
        endcase
    end

    assign busy = (count_reg == 2'd2) || clearing;
    assign push = start && !busy;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop_ok = pop && cmd_valid;
    assign cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule

@@ hw/rtl/pwc_back.sv @@
// back end: banked table scan, table update and result register
module pwc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  pwc_pkg::cmd_t cmd,
    output logic          pop,
    output logic          clearing,
    output logic          done,
    output pwc_pkg::rsp_t result
);
    import pwc_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_DECIDE} state_t;

    localparam logic [ROW_W-1:0] V4_ROWS_W = ROW_W'(V4_ROWS);
    localparam logic [ROW_W-1:0] V6_ROWS_W = ROW_W'(V6_ROWS);
    localparam logic [ROW_W-1:0] PORT_ROWS_W = ROW_W'(PORT_ROWS);
    localparam logic [ROW_W-1:0] MAX_ROWS_W = ROW_W'(MAX_ROWS);
    localparam logic [ROW_W-1:0] ROW_ONE = ROW_W'(1);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    tbl_t              tbl_reg, tbl_next;
    logic [ROW_W-1:0]  rd_row_reg, rd_row_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [ROW_W-1:0]  chk_row_reg, chk_row_next;
    logic              hit_reg, hit_next;
    logic              free_found_reg, free_found_next;
    logic              done_reg, done_next;
    rsp_t              result_reg, result_next;

    logic [ROW_W-1:0]  hit_row_reg, free_row_reg;
    logic [LANE_W-1:0] hit_lane_reg, free_lane_reg;
    gen_row_t          hit_data_reg, free_data_reg;
    logic              cap_hit, cap_free;

    v4_row_t   v4_rd, v4_wr;
    v6_row_t   v6_rd, v6_wr;
    port_row_t port_rd, port_wr;
    logic      v4_we, v6_we, port_we;
    logic [ROW_W-1:0] wr_row;

    gen_row_t          cur;
    gen_row_t          wr_gen;
    logic [ROW_W-1:0]  rows_cur;
    int                ents_cur;
    logic [127:0]      cmp_key;
    logic [LANES-1:0]  match, free;
    logic              hit_any, free_any;
    logic [LANE_W-1:0] hit_lane, free_lane;
    logic [LANE_W-1:0] wr_lane;
    logic              do_write;

    pwc_ram #(.DEPTH(V4_ROWS), .WIDTH($bits(v4_row_t)), .AW(V4_AW)) u_v4_ram (
        .clk(clk), .we(v4_we), .waddr(wr_row[V4_AW-1:0]), .wdata(v4_wr),
        .raddr(rd_row_reg[V4_AW-1:0]), .rdata(v4_rd)
    );
    pwc_ram #(.DEPTH(V6_ROWS), .WIDTH($bits(v6_row_t)), .AW(V6_AW)) u_v6_ram (
        .clk(clk), .we(v6_we), .waddr(wr_row[V6_AW-1:0]), .wdata(v6_wr),
        .raddr(rd_row_reg[V6_AW-1:0]), .rdata(v6_rd)
    );
    pwc_ram #(.DEPTH(PORT_ROWS), .WIDTH($bits(port_row_t)), .AW(PORT_AW)) u_port_ram (
        .clk(clk), .we(port_we), .waddr(wr_row[PORT_AW-1:0]), .wdata(port_wr),
        .raddr(rd_row_reg[PORT_AW-1:0]), .rdata(port_rd)
    );

    // row view of the table being scanned
    always_comb
    begin
        cur = '0;
        rows_cur = V4_ROWS_W;
        ents_cur = V4_ENTRIES;
        cmp_key = cmd_reg.key;
        case (tbl_reg)
            TBL_V6:
            begin
                rows_cur = V6_ROWS_W;
                ents_cur = V6_ENTRIES;
                cur.used = v6_rd.used;
                for (int l = 0; l < LANES; l++)
                begin
                    cur.key[l] = v6_rd.key[l];
                    cur.allow[l] = v6_rd.allow[l];
                end
            end
            TBL_PORT:
            begin
                rows_cur = PORT_ROWS_W;
                ents_cur = PORT_ENTRIES;
                cmp_key = {112'd0, cmd_reg.port};
                cur.used = port_rd.used;
                for (int l = 0; l < LANES; l++)
                begin
                    cur.key[l] = {112'd0, port_rd.key[l]};
                    cur.allow[l] = port_rd.allow[l];
                end
            end
            default:
            begin
                cur.used = v4_rd.used;
                for (int l = 0; l < LANES; l++)
                begin
                    cur.key[l] = {96'd0, v4_rd.key[l]};
                    cur.allow[l] = v4_rd.allow[l];
                end
            end
        endcase
    end

    // lane compare and lowest-lane pick
    always_comb
    begin
        hit_lane = '0;
        free_lane = '0;
        for (int l = 0; l < LANES; l++)
        begin
            logic ok;
            ok = (32'({chk_row_reg, LANE_W'(l)}) < 32'(ents_cur));
            match[l] = ok && cur.used[l] && (cur.key[l] == cmp_key);
            free[l] = ok && !cur.used[l];
        end
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (match[l]) hit_lane = LANE_W'(l);
            if (free[l]) free_lane = LANE_W'(l);
        end
        hit_any = |match;
        free_any = |free;
    end

    // row written back on update, or a zero row during the clearing pass
    always_comb
    begin
        wr_gen = hit_reg ? hit_data_reg : free_data_reg;
        wr_lane = hit_reg ? hit_lane_reg : free_lane_reg;
        if (cmd_reg.remove_entry)
        begin
            wr_gen.used[wr_lane] = 1'b0;
        end
        else
        begin
            wr_gen.used[wr_lane] = 1'b1;
            wr_gen.key[wr_lane] = cmp_key;
            wr_gen.allow[wr_lane] = cmd_reg.allow_mask;
        end
        if (state_reg == ST_CLEAR)
        begin
            wr_gen = '0;
        end
        v4_wr.used = wr_gen.used;
        v6_wr.used = wr_gen.used;
        port_wr.used = wr_gen.used;
        for (int l = 0; l < LANES; l++)
        begin
            v4_wr.key[l] = wr_gen.key[l][31:0];
            v6_wr.key[l] = wr_gen.key[l];
            port_wr.key[l] = wr_gen.key[l][15:0];
            v4_wr.allow[l] = wr_gen.allow[l];
            v6_wr.allow[l] = wr_gen.allow[l];
            port_wr.allow[l] = wr_gen.allow[l];
        end
    end

    assign do_write = (state_reg == ST_DECIDE) && (cmd_reg.kind == CMD_UPDATE)
                      && (cmd_reg.remove_entry ? hit_reg : (hit_reg || free_found_reg));
    assign wr_row = (state_reg == ST_CLEAR) ? rd_row_reg
                    : (hit_reg ? hit_row_reg : free_row_reg);
    assign v4_we = ((state_reg == ST_CLEAR) && (rd_row_reg < V4_ROWS_W))
                   || (do_write && tbl_reg == TBL_V4);
    assign v6_we = ((state_reg == ST_CLEAR) && (rd_row_reg < V6_ROWS_W))
                   || (do_write && tbl_reg == TBL_V6);
    assign port_we = ((state_reg == ST_CLEAR) && (rd_row_reg < PORT_ROWS_W))
                     || (do_write && tbl_reg == TBL_PORT);

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        tbl_next = tbl_reg;
        rd_row_next = rd_row_reg;
        chk_valid_next = 1'b0;
        chk_row_next = chk_row_reg;
        hit_next = hit_reg;
        free_found_next = free_found_reg;
        done_next = 1'b0;
        result_next = result_reg;
        pop = 1'b0;
        cap_hit = 1'b0;
        cap_free = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                rd_row_next = rd_row_reg + ROW_ONE;
                if (rd_row_reg == MAX_ROWS_W - ROW_ONE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    cmd_next = cmd;
                    if (cmd.kind == CMD_DONE)
                    begin
                        done_next = 1'b1;
                        result_next = '{cmd.verdict, MATCH_NONE, STATUS_OK};
                    end
                    else
                    begin
                        tbl_next = cmd.tbl;
                        rd_row_next = '0;
                        hit_next = 1'b0;
                        free_found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_row_reg < rows_cur)
                begin
                    rd_row_next = rd_row_reg + ROW_ONE;
                    chk_valid_next = 1'b1;
                    chk_row_next = rd_row_reg;
                end
                if (chk_valid_reg)
                begin
                    if (hit_any)
                    begin
                        cap_hit = 1'b1;
                        hit_next = 1'b1;
                        chk_valid_next = 1'b0;
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        if (free_any && !free_found_reg)
                        begin
                            cap_free = 1'b1;
                            free_found_next = 1'b1;
                        end
                        if (chk_row_reg == rows_cur - ROW_ONE)
                        begin
                            chk_valid_next = 1'b0;
                            state_next = ST_DECIDE;
                        end
                    end
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (cmd_reg.kind == CMD_UPDATE)
                begin
                    done_next = 1'b1;
                    result_next = '{VERDICT_PASS, MATCH_NONE, STATUS_OK};
                    if (cmd_reg.remove_entry && !hit_reg)
                    begin
                        result_next.status = STATUS_ABSENT;
                    end
                    else if (!cmd_reg.remove_entry && !hit_reg && !free_found_reg)
                    begin
                        result_next.status = STATUS_FULL;
                    end
                end
                else if (hit_reg)
                begin
                    done_next = 1'b1;
                    result_next.status = STATUS_OK;
                    result_next.matched_table = (tbl_reg == TBL_PORT) ? MATCH_PORT
                                                                      : MATCH_SOURCE;
                    result_next.verdict = |(hit_data_reg.allow[hit_lane_reg] & cmd_reg.pm)
                                          ? VERDICT_REDIRECT : VERDICT_DROP;
                end
                else if (tbl_reg != TBL_PORT && cmd_reg.port_chk)
                begin
                    tbl_next = TBL_PORT;
                    rd_row_next = '0;
                    hit_next = 1'b0;
                    free_found_next = 1'b0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    done_next = 1'b1;
                    result_next = '{VERDICT_PASS, MATCH_NONE, STATUS_OK};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            tbl_reg <= TBL_V4;
            rd_row_reg <= '0;
            chk_valid_reg <= 1'b0;
            chk_row_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tbl_reg <= tbl_next;
            rd_row_reg <= rd_row_next;
            chk_valid_reg <= chk_valid_next;
            chk_row_reg <= chk_row_next;
            hit_reg <= hit_next;
            free_found_reg <= free_found_next;
            done_reg <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (cap_hit)
        begin
            hit_row_reg <= chk_row_reg;
            hit_lane_reg <= hit_lane;
            hit_data_reg <= cur;
        end
        if (cap_free)
        begin
            free_row_reg <= chk_row_reg;
            free_lane_reg <= free_lane;
            free_data_reg <= cur;
        end
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign done = done_reg;
    assign result = result_reg;

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done_reg)
        else $error("result during clearing pass");

    a_update_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status != STATUS_OK)
        |-> (result_reg.verdict == VERDICT_PASS && result_reg.matched_table == MATCH_NONE))
        else $error("update failure carries a verdict");

    a_port_scan_needs_l4: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && tbl_reg == TBL_PORT && cmd_reg.kind == CMD_LOOKUP)
        |-> cmd_reg.port_chk)
        else $error("port scan without parsed tcp or udp header");

    a_write_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR && (v4_we || v6_we || port_we))
        |-> (state_reg == ST_DECIDE && cmd_reg.kind == CMD_UPDATE))
        else $error("table write outside an update");
endmodule

@@ hw/rtl/packet_whitelist_classifier.sv @@
// top level of the packet whitelist classifier
//
// request channel: an item on item is a transfer at a rising edge where start
// is high and busy is low. result channel: done is high for one cycle with
// result; the receiver cannot stall it, so results are never held.
// a classify request that needs no lookup (arp, non-ip, header failure)
// completes without a table scan. a lookup or update scans one table, 16
// slots per cycle out of banked row memories; a source miss on parsed tcp
// or udp adds a scan of the port list. the scan stops early on a key hit.
// the memory row scan is what sets the rate. a two-entry queue sits between
// decode and the scan engine, so up to two requests are taken while one is
// being worked on. after reset a clearing pass writes every memory row;
// busy is high during it. results come out in request order.
module packet_whitelist_classifier (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pwc_pkg::req_t item,
    output logic          done,
    output pwc_pkg::rsp_t result
);
    import pwc_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic pop;
    logic clearing;

    pwc_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .clearing(clearing),
        .busy(busy), .pop(pop), .cmd_valid(cmd_valid), .cmd(cmd)
    );

    pwc_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .pop(pop),
        .clearing(clearing), .done(done), .result(result)
    );
endmodule
